// File: sv/lwu_pkg.sv
package lwu_pkg;

    localparam int MAX_ORDER    = 6;
    localparam int IDX_W        = 3;
    localparam int UPSAMPLE_DEF = 10;
    localparam logic [2:0] WP_RESET = 3'd5;

    // Divider sizing: the widest dividend is |term| * |x - x_j| < 2^92
    localparam int DIV_NW = 96;
    localparam int DIV_DW = 34;
    localparam int QUO_W  = 59;
    localparam logic [QUO_W-1:0] TERM_LIMIT = QUO_W'(1) << 58;

    // Step position: reciprocal multiply taken as this many partial products
    localparam int RCP_PARTS = 4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_DUP = 2'd2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic               last_of_run;
        logic [1:0]         status;
    } sample_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SHIFT,
        OP_DUP,
        OP_LDA,
        OP_LDB,
        OP_MULX,
        OP_DIVX,
        OP_TAKEX,
        OP_LDY,
        OP_LDXJ,
        OP_ZERO_T,
        OP_MLO,
        OP_MHI,
        OP_DIVT,
        OP_TAKET,
        OP_ACC,
        OP_OUT,
        OP_OUT_FEW
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] base;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic dup;
        logic t_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/lwu_div.sv
module lwu_div
    import lwu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [QUO_W-1:0]  quo
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] work_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic              round_up;
    logic [DIV_NW:0]   q_round;

    // Restoring step: one quotient bit per cycle
    assign trial    = {rem_reg, work_reg[DIV_NW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    // Round half away from zero on magnitudes, then cap
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign q_round  = {1'b0, work_reg} + (DIV_NW + 1)'(round_up);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                work_reg <= {work_reg[DIV_NW-2:0], ge};
                rem_reg  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            end
            else if (q_round > (DIV_NW + 1)'(TERM_LIMIT))
            begin
                quo_reg <= TERM_LIMIT;
            end
            else
            begin
                quo_reg <= q_round[QUO_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/lwu_dp.sv
module lwu_dp
    import lwu_pkg::*;
#(
    parameter  int UPSAMPLE = UPSAMPLE_DEF,
    localparam int STEP_W   = $clog2(UPSAMPLE)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [STEP_W-1:0] step,
    input  point_t            point,
    output dp_stat_t          stat,
    output logic              sample_valid,
    input  logic              sample_ready,
    output sample_t           sample
);

    localparam int M_W = 33 + STEP_W;

    // floor(n / UPSAMPLE) = (n * RCP) >> RCP_S, exact for n < 2^38
    localparam int RCP_S = 42;
    localparam int RCP_H = 21;
    localparam int NX_H  = 19;
    localparam logic [2*RCP_H-1:0] RCP =
        (2*RCP_H)'(((64'd1 << RCP_S) + 64'(UPSAMPLE) - 64'd1) / 64'(UPSAMPLE));

    logic signed [31:0] xw_reg [MAX_ORDER];
    logic signed [31:0] yw_reg [MAX_ORDER];

    logic signed [31:0] xa_reg;
    logic signed [32:0] delta_reg;
    logic [M_W-1:0]     m_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] xi_reg;
    logic signed [32:0] num_reg;
    logic signed [32:0] den_reg;
    logic signed [59:0] t_reg;
    logic [DIV_NW-1:0]  acc_reg;
    logic               neg_reg;
    logic signed [63:0] sum_reg;
    logic               dup_reg;
    logic               dup_next;
    sample_t            out_reg;
    logic               out_valid_reg;

    logic signed [31:0] xrd;
    logic signed [31:0] yrd;
    logic [32:0]        dx_mag;
    logic [59:0]        t_mag;
    logic [32:0]        n_mag;
    logic [32:0]        d_mag;
    logic [64:0]        mul_lo;
    logic [59:0]        mul_hi;
    logic [2*NX_H-1:0]  nx;
    logic [NX_H-1:0]    rcp_a;
    logic [RCP_H-1:0]   rcp_b;
    logic [NX_H+RCP_H-1:0] rcp_p;
    logic [DIV_NW-1:0]  rcp_term;
    logic [32:0]        x_quo;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic signed [33:0] sx_wide;
    logic signed [31:0] y_sat;
    logic               out_free;

    assign xrd    = xw_reg[cmd.addr];
    assign yrd    = yw_reg[cmd.addr];
    assign dx_mag = delta_reg[32] ? 33'(-delta_reg) : 33'(delta_reg);
    assign t_mag  = t_reg[59] ? 60'(-t_reg) : 60'(t_reg);
    assign n_mag  = num_reg[32] ? 33'(-num_reg) : 33'(num_reg);
    assign d_mag  = den_reg[32] ? 33'(-den_reg) : 33'(den_reg);
    assign mul_lo = t_mag[31:0] * n_mag;
    assign mul_hi = t_mag[58:32] * n_mag;

    // Step offset: one partial product of m * RCP per cycle, addr selects the halves
    assign nx     = (2*NX_H)'(m_reg);
    assign rcp_a  = cmd.addr[0] ? nx[2*NX_H-1:NX_H] : nx[NX_H-1:0];
    assign rcp_b  = cmd.addr[1] ? RCP[2*RCP_H-1:RCP_H] : RCP[RCP_H-1:0];
    assign rcp_p  = rcp_a * rcp_b;
    assign x_quo  = acc_reg[RCP_S+32:RCP_S];

    always_comb
    begin
        case (cmd.addr[1:0])
            2'd0:    rcp_term = DIV_NW'(rcp_p);
            2'd1:    rcp_term = DIV_NW'(rcp_p) << NX_H;
            2'd2:    rcp_term = DIV_NW'(rcp_p) << RCP_H;
            default: rcp_term = DIV_NW'(rcp_p) << (NX_H + RCP_H);
        endcase
    end

    assign div_start = (cmd.op == OP_DIVT);
    assign div_num   = acc_reg;
    assign div_den   = {1'b0, d_mag};

    assign sx_wide = delta_reg[32]
                   ? 34'({{2{xa_reg[31]}}, xa_reg}) - 34'({1'b0, x_quo})
                   : 34'({{2{xa_reg[31]}}, xa_reg}) + 34'({1'b0, x_quo});

    assign out_free = !out_valid_reg || sample_ready;

    always_comb
    begin
        if (sum_reg > 64'sd2147483647)
        begin
            y_sat = 32'sh7fffffff;
        end
        else if (sum_reg < -64'sd2147483648)
        begin
            y_sat = 32'sh80000000;
        end
        else
        begin
            y_sat = sum_reg[31:0];
        end
    end

    // Pairwise compare of the live window entries
    always_comb
    begin
        dup_next = 1'b0;
        for (int a = 0; a < MAX_ORDER; a++)
        begin
            for (int b = a + 1; b < MAX_ORDER; b++)
            begin
                if ((IDX_W'(a) >= cmd.base) && (xw_reg[a] == xw_reg[b]))
                begin
                    dup_next = 1'b1;
                end
            end
        end
    end

    lwu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SHIFT:
            begin
                for (int e = 0; e < MAX_ORDER - 1; e++)
                begin
                    xw_reg[e] <= xw_reg[e+1];
                    yw_reg[e] <= yw_reg[e+1];
                end
                xw_reg[MAX_ORDER-1] <= point.point_x;
                yw_reg[MAX_ORDER-1] <= point.point_y;
            end
            OP_DUP:    dup_reg   <= dup_next;
            OP_LDA:    xa_reg    <= xrd;
            OP_LDB:    delta_reg <= 33'(xrd) - 33'(xa_reg);
            // Bias by half a step so the reciprocal floor rounds to nearest
            OP_MULX:   m_reg     <= M_W'(dx_mag) * M_W'(step) + M_W'(UPSAMPLE / 2);
            OP_DIVX:
                acc_reg <= (cmd.addr[1:0] == 2'd0) ? rcp_term : acc_reg + rcp_term;
            OP_TAKEX:
            begin
                sx_reg  <= sx_wide[31:0];
                sum_reg <= '0;
            end
            OP_LDY:
            begin
                t_reg  <= {{28{yrd[31]}}, yrd};
                xi_reg <= xrd;
            end
            OP_LDXJ:
            begin
                num_reg <= 33'(sx_reg) - 33'(xrd);
                den_reg <= 33'(xi_reg) - 33'(xrd);
            end
            OP_ZERO_T: t_reg <= '0;
            OP_MLO:
            begin
                acc_reg <= DIV_NW'(mul_lo);
                neg_reg <= t_reg[59] ^ num_reg[32] ^ den_reg[32];
            end
            OP_MHI:    acc_reg <= acc_reg + (DIV_NW'(mul_hi) << 32);
            OP_TAKET:
                t_reg <= neg_reg ? -60'({1'b0, div_quo}) : 60'({1'b0, div_quo});
            OP_ACC:    sum_reg <= sum_reg + {{4{t_reg[59]}}, t_reg};
            OP_OUT:
            begin
                out_reg.sample_x    <= sx_reg;
                out_reg.sample_y    <= dup_reg ? 32'sd0 : y_sat;
                out_reg.last_of_run <= cmd.last;
                out_reg.status      <= dup_reg ? ST_DUP : ST_OK;
            end
            OP_OUT_FEW:
            begin
                out_reg.sample_x    <= '0;
                out_reg.sample_y    <= '0;
                out_reg.last_of_run <= 1'b1;
                out_reg.status      <= ST_FEW;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.op == OP_OUT) || (cmd.op == OP_OUT_FEW))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sample_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.dup      = dup_reg;
    assign stat.t_zero   = (t_reg == '0) || (num_reg == '0);
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    assign sample_valid = out_valid_reg;
    assign sample       = out_reg;

endmodule

// File: sv/lwu_ctrl.sv
module lwu_ctrl
    import lwu_pkg::*;
#(
    parameter  int UPSAMPLE = UPSAMPLE_DEF,
    localparam int STEP_W   = $clog2(UPSAMPLE)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  logic              point_last,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_data,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd,
    output logic [STEP_W-1:0] step
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_CHECK = 16'b0000_0000_0000_0010,
        S_FEW   = 16'b0000_0000_0000_0100,
        S_LDA   = 16'b0000_0000_0000_1000,
        S_LDB   = 16'b0000_0000_0001_0000,
        S_MULX  = 16'b0000_0000_0010_0000,
        S_DIVX  = 16'b0000_0000_0100_0000,
        S_WAITX = 16'b0000_0000_1000_0000,
        S_LDY   = 16'b0000_0001_0000_0000,
        S_JSEL  = 16'b0000_0010_0000_0000,
        S_MLO   = 16'b0000_0100_0000_0000,
        S_MHI   = 16'b0000_1000_0000_0000,
        S_DIVT  = 16'b0001_0000_0000_0000,
        S_WAITT = 16'b0010_0000_0000_0000,
        S_ACC   = 16'b0100_0000_0000_0000,
        S_OUT   = 16'b1000_0000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        wp_cfg_reg;
    logic [IDX_W-1:0]  ps_reg, ps_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [STEP_W-1:0] s_reg, s_next;
    logic              last_reg, last_next;

    logic [IDX_W-1:0]  wp;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  klast;
    logic              accept;
    logic              final_step;

    always_comb
    begin
        if (wp_cfg_reg < 3'd2)
        begin
            wp = IDX_W'(2);
        end
        else if (wp_cfg_reg > 3'(MAX_ORDER))
        begin
            wp = IDX_W'(MAX_ORDER);
        end
        else
        begin
            wp = IDX_W'(wp_cfg_reg);
        end
    end

    assign base       = IDX_W'(MAX_ORDER) - wp;
    assign klast      = last_reg ? wp - IDX_W'(2) : '0;
    assign accept     = point_valid && point_ready;
    assign final_step = (s_reg == STEP_W'(UPSAMPLE - 1)) && (k_reg == klast);
    assign point_ready = (state_reg == S_IDLE);
    assign step       = s_reg;

    always_comb
    begin
        state_next = state_reg;
        ps_next    = ps_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        last_next  = last_reg;
        cmd.op     = OP_NONE;
        cmd.addr   = '0;
        cmd.base   = base;
        cmd.last   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op     = OP_SHIFT;
                    last_next  = point_last;
                    if (ps_reg < IDX_W'(MAX_ORDER))
                    begin
                        ps_next = ps_reg + IDX_W'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (ps_reg < wp)
                begin
                    if (last_reg)
                    begin
                        ps_next    = '0;
                        state_next = S_FEW;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = OP_DUP;
                    k_next     = '0;
                    s_next     = '0;
                    state_next = S_LDA;
                end
            end
            S_FEW:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT_FEW;
                    state_next = S_IDLE;
                end
            end
            S_LDA:
            begin
                cmd.op     = OP_LDA;
                cmd.addr   = base + k_reg;
                state_next = S_LDB;
            end
            S_LDB:
            begin
                cmd.op     = OP_LDB;
                cmd.addr   = base + k_reg + IDX_W'(1);
                state_next = S_MULX;
            end
            S_MULX:
            begin
                cmd.op     = OP_MULX;
                j_next     = '0;
                state_next = S_DIVX;
            end
            // One partial product of the step reciprocal per cycle
            S_DIVX:
            begin
                cmd.op   = OP_DIVX;
                cmd.addr = j_reg;
                if (j_reg == IDX_W'(RCP_PARTS - 1))
                begin
                    state_next = S_WAITX;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_WAITX:
            begin
                cmd.op     = OP_TAKEX;
                i_next     = '0;
                state_next = stat.dup ? S_OUT : S_LDY;
            end
            S_LDY:
            begin
                cmd.op     = OP_LDY;
                cmd.addr   = base + i_reg;
                j_next     = '0;
                state_next = S_JSEL;
            end
            S_JSEL:
            begin
                if (j_reg == wp)
                begin
                    state_next = S_ACC;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
                else
                begin
                    cmd.op     = OP_LDXJ;
                    cmd.addr   = base + j_reg;
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                if (stat.t_zero)
                begin
                    cmd.op     = OP_ZERO_T;
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_JSEL;
                end
                else
                begin
                    cmd.op     = OP_MLO;
                    state_next = S_MHI;
                end
            end
            S_MHI:
            begin
                cmd.op     = OP_MHI;
                state_next = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.op     = OP_DIVT;
                state_next = S_WAITT;
            end
            S_WAITT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_TAKET;
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_JSEL;
                end
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (i_reg == wp - IDX_W'(1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_LDY;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op   = OP_OUT;
                    cmd.last = final_step;
                    if (s_reg != STEP_W'(UPSAMPLE - 1))
                    begin
                        s_next     = s_reg + STEP_W'(1);
                        state_next = S_LDA;
                    end
                    else if (k_reg != klast)
                    begin
                        s_next     = '0;
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_LDA;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            ps_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_cfg_reg <= WP_RESET;
            ps_reg     <= '0;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            s_reg      <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ps_reg    <= ps_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            s_reg     <= s_next;
            last_reg  <= last_next;
            if (cfg_wr_en)
            begin
                wp_cfg_reg <= cfg_wr_data;
            end
        end
    end

`ifndef SYNTH
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_WAITX) || (state_reg == S_WAITT))
        else $error("divider finished outside a wait state");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_OUT) || (cmd.op == OP_OUT_FEW)) |-> stat.out_free)
        else $error("result register overwritten while still held");

    a_accept_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CHECK))
        else $error("accepted request not checked");

    a_interval_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LDA) |-> (k_reg + IDX_W'(2) <= wp))
        else $error("interval index outside the window");
`endif

endmodule

// File: sv/lagrange_window_upsampler.sv
// Lagrange window upsampler. Each accepted request carries a point (x, y) in
// signed Q16.16; the block keeps the last window_points points (2..6, reset 5,
// out-of-range writes are clamped) and, once the window is full, emits the
// interval starting at the oldest window point as UPSAMPLE samples, each the
// Lagrange polynomial through the window evaluated at an evenly spaced x and
// saturated to 32 bits. A request flagged last_point emits every interval of
// the final window and starts a new data set; with too few points it emits a
// single sample with status 1. Duplicate x in the window gives samples with
// y = 0 and status 2. Every sample finds its x by a reciprocal multiply taken
// as four partial products, then forms wp*(wp-1) scaled products for its y,
// each divided on one shared bit-serial 96-step divider; a product whose term
// or factor is zero skips the divider, and with duplicate x no products are
// formed. Each sample also waits while the previous one is still held at the
// output. The next request is accepted once the previous one has computed its
// last sample, while that sample may still wait at the output.
module lagrange_window_upsampler
    import lwu_pkg::*;
#(
    parameter int UPSAMPLE = UPSAMPLE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    output logic       point_ready,
    input  point_t     point,
    output logic       sample_valid,
    input  logic       sample_ready,
    output sample_t    sample,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data
);

    localparam int STEP_W = $clog2(UPSAMPLE);

    // Command and status between sequencer and datapath
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [STEP_W-1:0] step;

    // Sequencer: holds the window fill count, loop indices and the config
    lwu_ctrl #(
        .UPSAMPLE (UPSAMPLE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_last  (point.last_point),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .cmd         (cmd),
        .step        (step)
    );

    // Datapath: window, operand registers, multiplier, divider, output stage
    lwu_dp #(
        .UPSAMPLE (UPSAMPLE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .step         (step),
        .point        (point),
        .stat         (stat),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample)
    );

endmodule

// File: test/lagrange_window_upsampler_test.sv
module lagrange_window_upsampler_test;
    import lwu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 200_000_000;
    localparam int  SETTLE       = 40;

    // Expected samples and a private copy of the window state.
    class sample_board;
        sample_t     due_q[$];
        int          xw[MAX_ORDER];
        int          yw[MAX_ORDER];
        int unsigned seen;
        int unsigned wp_reg;
        int          errors;
        int          checked;

        function void reset_state();
            due_q.delete();
            seen    = 0;
            wp_reg  = WP_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_window(logic [2:0] v);
            wp_reg = v;
        endfunction

        // Scale a term by num/den, round half away from zero, cap at 2^58.
        function longint scale_term(longint t, longint num, longint den);
            logic [127:0]    prod, quo, rem;
            longint unsigned mt, mn, md;
            bit              neg;
            if (t == 0 || num == 0)
                return 0;
            neg  = (t < 0) ^ ((num < 0) ^ (den < 0));
            mt   = t < 0 ? -t : t;
            mn   = num < 0 ? -num : num;
            md   = den < 0 ? -den : den;
            prod = 128'(mt) * 128'(mn);
            quo  = prod / 128'(md);
            rem  = prod % 128'(md);
            if (2 * rem >= 128'(md))
                quo++;
            if (quo > 128'(TERM_LIMIT))
                quo = 128'(TERM_LIMIT);
            return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function int poly_at(longint x, int base, int wp);
            longint sum, t;
            sum = 0;
            for (int i = 0; i < wp; i++)
            begin
                t = yw[base + i];
                for (int j = 0; j < wp; j++)
                    if (i != j)
                        t = scale_term(t, x - longint'(xw[base + j]),
                                       longint'(xw[base + i]) - longint'(xw[base + j]));
                sum += t;
            end
            if (sum > 64'sd2147483647)
                return 32'h7fffffff;
            if (sum < -64'sd2147483648)
                return 32'h80000000;
            return int'(sum);
        endfunction

        function void push_interval(int base, int wp, int k, bit dup);
            longint          x0, delta, sx;
            longint unsigned m, q;
            sample_t         s;
            x0    = xw[base + k];
            delta = longint'(xw[base + k + 1]) - x0;
            for (int j = 0; j < UPSAMPLE_DEF; j++)
            begin
                m  = (delta < 0 ? -delta : delta) * j;
                q  = (2 * m + UPSAMPLE_DEF) / (2 * UPSAMPLE_DEF);
                sx = delta < 0 ? x0 - longint'(q) : x0 + longint'(q);
                s.sample_x    = sx[31:0];
                s.sample_y    = dup ? 32'sd0 : poly_at(sx, base, wp);
                s.last_of_run = 1'b0;
                s.status      = dup ? ST_DUP : ST_OK;
                due_q.push_back(s);
            end
        endfunction

        function void note_point(point_t p);
            int      wp, base;
            bit      dup;
            sample_t s;
            wp   = wp_reg < 2 ? 2 : (wp_reg > MAX_ORDER ? MAX_ORDER : wp_reg);
            base = MAX_ORDER - wp;
            dup  = 1'b0;
            for (int i = 0; i < MAX_ORDER - 1; i++)
            begin
                xw[i] = xw[i + 1];
                yw[i] = yw[i + 1];
            end
            xw[MAX_ORDER - 1] = p.point_x;
            yw[MAX_ORDER - 1] = p.point_y;
            if (seen < MAX_ORDER)
                seen++;
            if (seen < wp)
            begin
                if (p.last_point)
                begin
                    seen          = 0;
                    s.sample_x    = '0;
                    s.sample_y    = '0;
                    s.last_of_run = 1'b1;
                    s.status      = ST_FEW;
                    due_q.push_back(s);
                end
                return;
            end
            for (int i = 0; i < wp; i++)
                for (int j = i + 1; j < wp; j++)
                    if (xw[base + i] == xw[base + j])
                        dup = 1'b1;
            if (!p.last_point)
                push_interval(base, wp, 0, dup);
            else
            begin
                for (int k = 0; k + 1 < wp; k++)
                    push_interval(base, wp, k, dup);
                seen = 0;
            end
            due_q[$].last_of_run = 1'b1;
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            checked++;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample x=%h y=%h last=%b st=%0d",
                             got.sample_x, got.sample_y, got.last_of_run, got.status);
                return;
            end
            want = due_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("sample %0d: want x=%h y=%h last=%b st=%0d, got x=%h y=%h last=%b st=%0d",
                             checked, want.sample_x, want.sample_y, want.last_of_run,
                             want.status, got.sample_x, got.sample_y, got.last_of_run,
                             got.status);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       point_valid;
    logic       point_ready;
    point_t     point;
    logic       sample_valid;
    logic       sample_ready;
    sample_t    sample;
    logic       cfg_wr_en;
    logic [2:0] cfg_wr_data;

    sample_board board;
    int          cycles;
    int          requests;
    int          burst_left;
    int          stall_mode;
    int          mode_left;

    lagrange_window_upsampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Cycle budget: abandon the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: check each accepted sample, then choose next cycle's ready.
    // Stall modes are picked at random: always ready, coin-flip, and long back-pressure.
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
            board.check_sample(sample);
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 300);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       sample_ready <= 1'b1;
            1:       sample_ready <= $urandom_range(0, 1);
            default: sample_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Hold the request until accepted; between bursts drop valid for a gap.
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic last);
        point_t p;
        p.point_x    = x;
        p.point_y    = y;
        p.last_point = last;
        point       <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (!point_ready);
        board.note_point(p);
        requests++;
        if (burst_left == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    // Wait for all expected samples, then let any sample-free request finish.
    task automatic drain();
        point_valid <= 1'b0;
        while (board.due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [2:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_window(v);
    endtask

    function automatic int rand_mag();
        return int'($urandom) >>> $urandom_range(0, 31);
    endfunction

    // Mostly well-formed data sets with rising x; some noise and broken sets.
    task automatic random_sets(input int count);
        int left, len, kind;
        logic signed [31:0] x;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            if (len > left)
                len = left;
            x = rand_mag();
            for (int i = 0; i < len; i++)
            begin
                if (kind == 0)
                    send_point($urandom, $urandom, 1'($urandom_range(0, 1)));
                else
                begin
                    if (kind == 1 && $urandom_range(0, 2) == 0)
                        ;   // repeat x: duplicate in the window
                    else if (kind == 2)
                        x = x - $urandom_range(1, 1 << $urandom_range(0, 24));
                    else if (i != 0)
                        x = x + $urandom_range(1, 1 << $urandom_range(0, 24));
                    send_point(x, rand_mag(), i == len - 1);
                end
            end
            left -= len;
        end
    endtask

    initial
    begin
        board       = new();
        board.reset_state();
        cycles      = 0;
        requests    = 0;
        burst_left  = 0;
        stall_mode  = 0;
        mode_left   = 0;
        rst_n       <= 1'b0;
        point_valid <= 1'b0;
        point       <= '0;
        sample_ready <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, window of five from reset.
        send_point(32'sd0, 32'sd0, 1'b1);                     // too few points
        send_point(32'h80000000, 32'h7fffffff, 1'b0);         // extremes, saturation
        send_point(32'hc0000000, 32'h80000000, 1'b0);
        send_point(32'sd0, 32'h7fffffff, 1'b0);
        send_point(32'h40000000, 32'h80000000, 1'b0);
        send_point(32'h7fffffff, 32'sd0, 1'b0);
        send_point(32'h7ffffffe, 32'sd65536, 1'b1);           // wrap in x order
        send_point(32'sd0, 32'sd65536, 1'b0);                 // duplicate x
        send_point(32'sd65536, 32'sd131072, 1'b0);
        send_point(32'sd65536, 32'sd196608, 1'b0);
        send_point(32'sd131072, -32'sd65536, 1'b0);
        send_point(32'sd196608, 32'sd0, 1'b1);
        send_point(32'sd500000, 32'sd1000, 1'b0);             // falling x
        send_point(32'sd400000, -32'sd2000, 1'b0);
        send_point(32'sd300000, 32'sd3000, 1'b0);
        send_point(32'sd200000, -32'sd4000, 1'b0);
        send_point(32'sd100000, 32'sd5000, 1'b1);
        send_point(32'sd10, 32'sd1, 1'b0);                    // short set
        send_point(32'sd20, 32'sd2, 1'b0);
        send_point(32'sd30, 32'sd3, 1'b0);
        send_point(32'sd40, 32'sd4, 1'b1);

        // Random phases; out-of-range writes clamp to the ends.
        write_window(3'd0);
        random_sets(110);
        write_window(3'd3);
        random_sets(70);
        write_window(3'd7);
        random_sets(15);
        write_window(3'd6);
        random_sets(10);
        write_window(3'd1);
        random_sets(40);
        write_window(3'd4);
        random_sets(20);
        drain();

        $display("%0d requests and %0d samples over window sizes 2 to 6, %0d cycles",
                 requests, board.checked, cycles);
        $display("%0d mismatches", board.errors);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: lagrange_window_upsampler.f
sv/lwu_pkg.sv
sv/lwu_div.sv
sv/lwu_dp.sv
sv/lwu_ctrl.sv
sv/lagrange_window_upsampler.sv
test/lagrange_window_upsampler_test.sv
